### design/ebec_pkg.sv
// ----------------------------------------------------------------------------
// ebec_pkg
// Shared types and constants for the encoder and button event capture block.
// ----------------------------------------------------------------------------
package ebec_pkg;

  // Default channel counts.
  localparam int NUM_ENCODERS_DEF = 4;
  localparam int NUM_BUTTONS_DEF  = 6;

  // Field widths that do not depend on the channel counts.
  localparam int DELTA_W    = 8;
  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 16;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FETCH  = 1'b1;

  // Register word index (paddr[2]).
  localparam logic REG_DEBOUNCE = 1'b0;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd10;

  // Transition table indexed by {previous pair, new pair}. Only moves out of
  // state 00 produce a step.
  localparam logic signed [DELTA_W-1:0] STEP_TABLE [16] = '{
    8'sd0, -8'sd1, 8'sd1, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0,
    8'sd0,  8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0
  };

  // Qualified per-item strobes for the channel banks.
  typedef struct packed {
    logic sample;
    logic fetch;
  } ctl_t;

  // What a channel bank reports back for the current item.
  typedef struct packed {
    logic hit;    // a sample raised a new pending event
    logic found;  // a fetch found a pending channel
  } evt_t;

endpackage

### design/encoder_button_event_capture_top.sv
// ----------------------------------------------------------------------------
// encoder_button_event_capture_top
// Quadrature encoder decoding and button debounce with fetchable events.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock cycle while in_stall is low
// and returns exactly one result transaction for each, in order. A
// transaction passes an input register and then a result register; all
// per-channel work for one transaction is a single pass of
// parallel lane logic (one table lookup and one 8-bit add per encoder, one
// 32-bit add and compare per button) between those two registers. A sample
// transaction with capture enabled updates the encoder histories,
// accumulators and button debounce state; a fetch transaction reports the
// lowest-numbered pending encoder with its accumulated delta and the
// lowest-numbered pending button, then clears both pending masks and zeroes
// the reported accumulator. The debounce time is written over the APB port
// at byte address 0 and should only be changed while no transaction is in
// flight.
// ----------------------------------------------------------------------------
module encoder_button_event_capture_top #(
  parameter int NUM_ENCODERS = ebec_pkg::NUM_ENCODERS_DEF,
  parameter int NUM_BUTTONS  = ebec_pkg::NUM_BUTTONS_DEF,
  parameter int ENC_IW       = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1,
  parameter int BTN_IW       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic                                 in_capture_enable,
  input  logic [NUM_ENCODERS-1:0]              in_enc_a_pins,
  input  logic [NUM_ENCODERS-1:0]              in_enc_b_pins,
  input  logic [NUM_BUTTONS-1:0]               in_button_levels,
  input  logic [ebec_pkg::TIME_W-1:0]          in_now_ms,

  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_update_pending,
  output logic                                 out_enc_event,
  output logic [ENC_IW-1:0]                    out_enc_index,
  output logic signed [ebec_pkg::DELTA_W-1:0]  out_enc_delta,
  output logic                                 out_button_event,
  output logic [BTN_IW-1:0]                    out_button_index,

  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ebec_pkg::APB_AW-1:0]          paddr,
  input  logic [ebec_pkg::APB_DW-1:0]          pwdata,
  output logic [ebec_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  // Input register.
  logic                            s1_valid_r;
  logic                            s1_cmd_r;
  logic                            s1_cap_r;
  logic [NUM_ENCODERS-1:0]         s1_a_r;
  logic [NUM_ENCODERS-1:0]         s1_b_r;
  logic [NUM_BUTTONS-1:0]          s1_lv_r;
  logic [ebec_pkg::TIME_W-1:0]     s1_now_r;

  // Result register.
  logic                                 out_valid_r;
  logic                                 upd_r;
  logic                                 enc_ev_r;
  logic [ENC_IW-1:0]                    enc_idx_r;
  logic signed [ebec_pkg::DELTA_W-1:0]  enc_dlt_r;
  logic                                 btn_ev_r;
  logic [BTN_IW-1:0]                    btn_idx_r;

  // Shared flag: some event is waiting to be fetched.
  logic                            any_upd_r;
  logic                            any_upd_nxt;

  logic                                 in_accept;
  logic                                 s1_fire;
  ebec_pkg::ctl_t                       ctl;
  ebec_pkg::evt_t                       enc_evt;
  ebec_pkg::evt_t                       btn_evt;
  logic [ENC_IW-1:0]                    enc_idx;
  logic signed [ebec_pkg::DELTA_W-1:0]  enc_dlt;
  logic [BTN_IW-1:0]                    btn_idx;
  logic [ebec_pkg::DEBOUNCE_W-1:0]      debounce_ms;

  // The input register moves on whenever the result register is free or is
  // being emptied in this cycle, so a stalled result does not block intake
  // until the input register itself is full.
  assign s1_fire   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r <= in_cmd;
      s1_cap_r <= in_capture_enable;
      s1_a_r   <= in_enc_a_pins;
      s1_b_r   <= in_enc_b_pins;
      s1_lv_r  <= in_button_levels;
      s1_now_r <= in_now_ms;
    end
  end

  // A sample only acts with capture enabled; a fetch only acts while
  // something is pending, otherwise the state is left alone.
  assign ctl.sample = s1_fire && (s1_cmd_r == ebec_pkg::CMD_SAMPLE) && s1_cap_r;
  assign ctl.fetch  = s1_fire && (s1_cmd_r == ebec_pkg::CMD_FETCH) && any_upd_r;

  ebec_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .debounce_ms (debounce_ms)
  );

  ebec_enc #(
    .NUM_ENCODERS (NUM_ENCODERS),
    .ENC_IW       (ENC_IW)
  ) u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .a_pins    (s1_a_r),
    .b_pins    (s1_b_r),
    .evt       (enc_evt),
    .sel_index (enc_idx),
    .sel_delta (enc_dlt)
  );

  ebec_btn #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .BTN_IW      (BTN_IW)
  ) u_btn (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .levels      (s1_lv_r),
    .now_ms      (s1_now_r),
    .debounce_ms (debounce_ms),
    .evt         (btn_evt),
    .sel_index   (btn_idx)
  );

  // A fetch that acts always empties both masks, so the flag drops with it.
  always_comb begin
    any_upd_nxt = any_upd_r;
    if (ctl.sample) begin
      any_upd_nxt = any_upd_r | enc_evt.hit | btn_evt.hit;
    end else if (ctl.fetch) begin
      any_upd_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_upd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      any_upd_r <= any_upd_nxt;
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Event fields read zero unless the fetch found something, which the banks
  // already guarantee by driving zero in every other case.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      upd_r     <= any_upd_nxt;
      enc_ev_r  <= enc_evt.found;
      enc_idx_r <= enc_idx;
      enc_dlt_r <= enc_dlt;
      btn_ev_r  <= btn_evt.found;
      btn_idx_r <= btn_idx;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_update_pending = upd_r;
  assign out_enc_event      = enc_ev_r;
  assign out_enc_index      = enc_idx_r;
  assign out_enc_delta      = enc_dlt_r;
  assign out_button_event   = btn_ev_r;
  assign out_button_index   = btn_idx_r;

endmodule

### design/ebec_cfg.sv
// ----------------------------------------------------------------------------
// ebec_cfg
// APB register file holding the debounce time.
// ----------------------------------------------------------------------------
module ebec_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ebec_pkg::APB_AW-1:0]       paddr,
  input  logic [ebec_pkg::APB_DW-1:0]       pwdata,
  output logic [ebec_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  output logic [ebec_pkg::DEBOUNCE_W-1:0]   debounce_ms
);

  logic [ebec_pkg::DEBOUNCE_W-1:0] debounce_r;
  logic [ebec_pkg::DEBOUNCE_W-1:0] debounce_nxt;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == ebec_pkg::REG_DEBOUNCE);

  always_comb begin
    debounce_nxt = debounce_r;
    if (wr_en) begin
      debounce_nxt = pwdata[ebec_pkg::DEBOUNCE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= ebec_pkg::DEBOUNCE_RST;
    end else begin
      debounce_r <= debounce_nxt;
    end
  end

  // Only bit 2 selects a word; the byte offset bits are ignored.
  always_comb begin
    prdata = '0;
    if ((paddr[2] == ebec_pkg::REG_DEBOUNCE) && (paddr[1:0] == paddr[1:0])) begin
      prdata = {{(ebec_pkg::APB_DW-ebec_pkg::DEBOUNCE_W){1'b0}}, debounce_r};
    end
  end

  assign debounce_ms = debounce_r;

endmodule

### design/ebec_enc.sv
// ----------------------------------------------------------------------------
// ebec_enc
// Quadrature encoder bank: per-encoder pin history, step accumulators and
// pending mask, with lowest-pending selection for fetches.
// ----------------------------------------------------------------------------
module ebec_enc #(
  parameter int NUM_ENCODERS = ebec_pkg::NUM_ENCODERS_DEF,
  parameter int ENC_IW       = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ebec_pkg::ctl_t                       ctl,
  input  logic [NUM_ENCODERS-1:0]              a_pins,
  input  logic [NUM_ENCODERS-1:0]              b_pins,
  output ebec_pkg::evt_t                       evt,
  output logic [ENC_IW-1:0]                    sel_index,
  output logic signed [ebec_pkg::DELTA_W-1:0]  sel_delta
);

  logic [1:0]                          last_r   [NUM_ENCODERS];
  logic [1:0]                          last_nxt [NUM_ENCODERS];
  logic signed [ebec_pkg::DELTA_W-1:0] acc_r    [NUM_ENCODERS];
  logic signed [ebec_pkg::DELTA_W-1:0] acc_nxt  [NUM_ENCODERS];
  logic [NUM_ENCODERS-1:0]             pend_r;
  logic [NUM_ENCODERS-1:0]             pend_nxt;

  always_comb begin
    logic [1:0]                          pair;
    logic signed [ebec_pkg::DELTA_W-1:0] step;
    logic                                found;
    pair      = '0;
    step      = '0;
    found     = 1'b0;
    pend_nxt  = pend_r;
    evt       = '0;
    sel_index = '0;
    sel_delta = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      last_nxt[i] = last_r[i];
      acc_nxt[i]  = acc_r[i];
    end

    if (ctl.sample) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        pair        = {a_pins[i], b_pins[i]};
        step        = ebec_pkg::STEP_TABLE[{last_r[i], pair}];
        last_nxt[i] = pair;
        if (step != '0) begin
          acc_nxt[i]  = acc_r[i] + step;
          pend_nxt[i] = 1'b1;
          evt.hit     = 1'b1;
        end
      end
    end else if (ctl.fetch) begin
      pend_nxt = '0;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        if (pend_r[i] && !found) begin
          found      = 1'b1;
          sel_index  = ENC_IW'(i);
          sel_delta  = acc_r[i];
          acc_nxt[i] = '0;
        end
      end
      evt.found = found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        last_r[i] <= '0;
        acc_r[i]  <= '0;
      end
    end else begin
      pend_r <= pend_nxt;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        last_r[i] <= last_nxt[i];
        acc_r[i]  <= acc_nxt[i];
      end
    end
  end

endmodule

### design/ebec_btn.sv
// ----------------------------------------------------------------------------
// ebec_btn
// Button bank: press time capture, release debounce and pending mask, with
// lowest-pending selection for fetches.
// ----------------------------------------------------------------------------
module ebec_btn #(
  parameter int NUM_BUTTONS = ebec_pkg::NUM_BUTTONS_DEF,
  parameter int BTN_IW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ebec_pkg::ctl_t                    ctl,
  input  logic [NUM_BUTTONS-1:0]            levels,
  input  logic [ebec_pkg::TIME_W-1:0]       now_ms,
  input  logic [ebec_pkg::DEBOUNCE_W-1:0]   debounce_ms,
  output ebec_pkg::evt_t                    evt,
  output logic [BTN_IW-1:0]                 sel_index
);

  // Press times need no reset: a time is only read while its button is armed.
  logic [ebec_pkg::TIME_W-1:0] press_r   [NUM_BUTTONS];
  logic [ebec_pkg::TIME_W-1:0] press_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]      armed_r;
  logic [NUM_BUTTONS-1:0]      armed_nxt;
  logic [NUM_BUTTONS-1:0]      pend_r;
  logic [NUM_BUTTONS-1:0]      pend_nxt;
  logic [NUM_BUTTONS-1:0]      expired;

  // The deadline sum wraps at 32 bits, as does the comparison time base.
  always_comb begin
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      expired[k] = now_ms >
                   (press_r[k] + {{(ebec_pkg::TIME_W-ebec_pkg::DEBOUNCE_W){1'b0}}, debounce_ms});
    end
  end

  always_comb begin
    logic found;
    found     = 1'b0;
    armed_nxt = armed_r;
    pend_nxt  = pend_r;
    evt       = '0;
    sel_index = '0;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      press_nxt[k] = press_r[k];
    end

    if (ctl.sample) begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        if (!levels[k]) begin
          press_nxt[k] = now_ms;
          armed_nxt[k] = 1'b1;
        end else if (armed_r[k] && expired[k]) begin
          armed_nxt[k] = 1'b0;
          pend_nxt[k]  = 1'b1;
          evt.hit      = 1'b1;
        end
      end
    end else if (ctl.fetch) begin
      pend_nxt = '0;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        if (pend_r[k] && !found) begin
          found     = 1'b1;
          sel_index = BTN_IW'(k);
        end
      end
      evt.found = found;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      press_r[k] <= press_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
      pend_r  <= '0;
    end else begin
      armed_r <= armed_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

### design/ebec_chk.sv
// ----------------------------------------------------------------------------
// ebec_chk
// Port-level checks for the encoder and button event capture block.
// ----------------------------------------------------------------------------
module ebec_chk #(
  parameter int NUM_ENCODERS = ebec_pkg::NUM_ENCODERS_DEF,
  parameter int NUM_BUTTONS  = ebec_pkg::NUM_BUTTONS_DEF,
  parameter int ENC_IW       = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1,
  parameter int BTN_IW       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_update_pending,
  input logic                                 out_enc_event,
  input logic [ENC_IW-1:0]                    out_enc_index,
  input logic signed [ebec_pkg::DELTA_W-1:0]  out_enc_delta,
  input logic                                 out_button_event,
  input logic [BTN_IW-1:0]                    out_button_index
);

  // A fetch that reports anything has emptied everything pending.
  a_event_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_enc_event || out_button_event) |-> !out_update_pending)
    else $error("event reported while update still pending");

  a_no_enc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_enc_event |-> (out_enc_index == '0) && (out_enc_delta == '0))
    else $error("encoder fields set without an encoder event");

  a_no_btn_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_button_event |-> (out_button_index == '0))
    else $error("button index set without a button event");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_enc_delta)
      && $stable(out_enc_index) && $stable(out_button_index)
      && $stable(out_update_pending))
    else $error("stalled result changed");

endmodule

bind encoder_button_event_capture_top ebec_chk #(
  .NUM_ENCODERS (NUM_ENCODERS),
  .NUM_BUTTONS  (NUM_BUTTONS),
  .ENC_IW       (ENC_IW),
  .BTN_IW       (BTN_IW)
) u_ebec_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_update_pending (out_update_pending),
  .out_enc_event      (out_enc_event),
  .out_enc_index      (out_enc_index),
  .out_enc_delta      (out_enc_delta),
  .out_button_event   (out_button_event),
  .out_button_index   (out_button_index)
);
